// ===== hdl/wts_pkg.sv =====
// ----------------------------------------------------------------------------
// wts_pkg
// shared constants and helpers for the world-to-screen projection core
// ----------------------------------------------------------------------------
`default_nettype none
package wts_pkg;
   localparam int FracBitsDefault = 16;
   localparam int DataW = 32;
   localparam int CsrAddrW = 6;
   localparam int SizeW = 14;

   localparam logic [2:0] REG_ROW0_01 = 3'd0;
   localparam logic [2:0] REG_ROW0_23 = 3'd1;
   localparam logic [2:0] REG_ROW1_01 = 3'd2;
   localparam logic [2:0] REG_ROW1_23 = 3'd3;
   localparam logic [2:0] REG_ROW3_01 = 3'd4;
   localparam logic [2:0] REG_ROW3_23 = 3'd5;
   localparam logic [2:0] REG_WIDTH   = 3'd6;
   localparam logic [2:0] REG_HEIGHT  = 3'd7;

   // saturate a 64-bit signed value to 32 bits
   function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh000000007FFFFFFF) r = 32'sh7FFFFFFF;
      else if (v < -64'sh0000000080000000) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== hdl/wts_divider.sv =====
// ----------------------------------------------------------------------------
// wts_divider
// pipelined signed restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module wts_divider #(
   parameter int NumW = 48,
   parameter int TagW = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire logic signed [NumW-1:0] in_num,
   input  wire logic [30:0]            in_den,
   input  wire logic [TagW-1:0]        in_tag,
   output logic                        out_valid,
   output logic signed [NumW:0]        out_quo,
   output logic [TagW-1:0]             out_tag
);
   // magnitude divide; |num| fits NumW bits, quotient NumW bits
   logic [NumW-1:0] rem_ff  [NumW+1];
   logic [NumW-1:0] quo_ff  [NumW+1];
   logic [30:0]     den_ff  [NumW+1];
   logic            neg_ff  [NumW+1];
   logic [TagW-1:0] tag_ff  [NumW+1];
   logic            vld_ff  [NumW+1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else vld_ff[0] <= in_valid;
      quo_ff[0] <= in_num[NumW-1] ? NumW'(-in_num) : NumW'(in_num);
      rem_ff[0] <= '0;
      den_ff[0] <= in_den;
      neg_ff[0] <= in_num[NumW-1];
      tag_ff[0] <= in_tag;
   end

   for (genvar s = 0; s < NumW; s++) begin : g_stage
      logic [NumW:0]   trial;
      logic [NumW-1:0] rem_in;
      logic [NumW-1:0] quo_in;
      always_comb begin
         trial = {rem_ff[s], quo_ff[s][NumW-1]} - {{(NumW-30){1'b0}}, den_ff[s]};
         if (trial[NumW]) begin
            rem_in = {rem_ff[s][NumW-2:0], quo_ff[s][NumW-1]};
            quo_in = {quo_ff[s][NumW-2:0], 1'b0};
         end else begin
            rem_in = trial[NumW-1:0];
            quo_in = {quo_ff[s][NumW-2:0], 1'b1};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) vld_ff[s+1] <= 1'b0;
         else vld_ff[s+1] <= vld_ff[s];
         rem_ff[s+1] <= rem_in;
         quo_ff[s+1] <= quo_in;
         den_ff[s+1] <= den_ff[s];
         neg_ff[s+1] <= neg_ff[s];
         tag_ff[s+1] <= tag_ff[s];
      end
   end

   assign out_valid = vld_ff[NumW];
   assign out_quo   = neg_ff[NumW] ? -$signed({1'b0, quo_ff[NumW]})
                                   : $signed({1'b0, quo_ff[NumW]});
   assign out_tag   = tag_ff[NumW];
endmodule
`default_nettype wire

// ===== hdl/world_to_screen_projection_core.sv =====
// ----------------------------------------------------------------------------
// world_to_screen_projection_core
// fixed-point perspective projection of world points to screen pixels
// ----------------------------------------------------------------------------
// usage:
//   - pulse start with req_pos_x/y/z while busy is low; busy is tied low, so
//     a new transaction can be issued every cycle
//   - one result per transaction appears on rsp_* for a single cycle,
//     marked by rsp_valid; the receiver cannot stall, results are never held
//   - the path from the accepting edge to rsp_valid is registered in a product
//     stage, a dot-sum stage, a FRAC_BITS+33 stage bit-per-cycle divider pair,
//     an offset stage and an output register; the default FRAC_BITS of 16
//     gives Q16.16 operands
//   - throughput is one transaction per cycle, set by the pipelined divider
//   - matrix rows and display size are written over the csr port; write
//     only while the pipeline is empty
//   - reset clears all valid bits and loads the register reset values
// ----------------------------------------------------------------------------
`default_nettype none
module world_to_screen_projection_core
   import wts_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic signed [31:0]      req_pos_x,
   input  wire logic signed [31:0]      req_pos_y,
   input  wire logic signed [31:0]      req_pos_z,
   output logic                         rsp_valid,
   output logic                         rsp_in_front,
   output logic signed [31:0]           rsp_screen_x,
   output logic signed [31:0]           rsp_screen_y,
   output logic signed [31:0]           rsp_clip_w,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrW-1:0]     csr_paddr,
   input  wire logic [63:0]             csr_pwdata,
   output logic [63:0]                  csr_prdata,
   output logic                         csr_pready
);
   localparam logic signed [31:0] WMin = 32'(((1 << FRAC_BITS) + 50) / 100);
   localparam int NumW = 32 + FRAC_BITS;
   localparam int TagW = 1 + 32;

   // ------------------------------------------------------------------ csr
   logic [63:0] mat_ff [6];
   logic [SizeW-1:0] width_ff, height_ff;
   logic [2:0] reg_idx;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[5:3];
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) mat_ff[i] <= '0;
         width_ff  <= SizeW'(1920);
         height_ff <= SizeW'(1080);
      end else if (csr_wr && csr_paddr[2:0] == 3'd0) begin
         unique case (reg_idx)
            REG_WIDTH:  width_ff  <= csr_pwdata[SizeW-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[SizeW-1:0];
            default:    mat_ff[reg_idx] <= csr_pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_WIDTH:  csr_prdata = {50'd0, width_ff};
         REG_HEIGHT: csr_prdata = {50'd0, height_ff};
         default:    csr_prdata = mat_ff[reg_idx];
      endcase
   end

   assign busy = 1'b0;

   // ---------------------------------------------- stage 1: 9 products
   logic               v1_ff;
   logic signed [63:0] p_ff [3][3];  // [row][col]
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= start;
      for (int r = 0; r < 3; r++) begin
         p_ff[r][0] <= $signed(mat_ff[2*r][31:0])    * req_pos_x;
         p_ff[r][1] <= $signed(mat_ff[2*r][63:32])   * req_pos_y;
         p_ff[r][2] <= $signed(mat_ff[2*r+1][31:0])  * req_pos_z;
      end
   end

   // ------------------------------------- stage 2: floor and sum, saturate
   logic               v2_ff;
   logic signed [31:0] dot_ff [3];
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      for (int r = 0; r < 3; r++)
         dot_ff[r] <= sat64(64'(p_ff[r][0] >>> FRAC_BITS) + 64'(p_ff[r][1] >>> FRAC_BITS)
                    + 64'(p_ff[r][2] >>> FRAC_BITS)
                    + 64'($signed(mat_ff[2*r+1][63:32])));
   end

   // ---------------------------------------- stage 3: w test, feed divider
   logic front;
   assign front = dot_ff[2] > WMin;

   logic signed [NumW:0] qx, qy;
   logic [TagW-1:0] tag_x, tag_y;
   logic dv_x, dv_y;

   wts_divider #(.NumW(NumW), .TagW(TagW)) u_div_x (
      .clock, .reset, .in_valid(v2_ff),
      .in_num(NumW'($signed(dot_ff[0])) <<< FRAC_BITS),
      .in_den(dot_ff[2][30:0]), .in_tag({front, dot_ff[2]}),
      .out_valid(dv_x), .out_quo(qx), .out_tag(tag_x));

   wts_divider #(.NumW(NumW), .TagW(TagW)) u_div_y (
      .clock, .reset, .in_valid(v2_ff),
      .in_num(NumW'($signed(dot_ff[1])) <<< FRAC_BITS),
      .in_den(dot_ff[2][30:0]), .in_tag({front, dot_ff[2]}),
      .out_valid(dv_y), .out_quo(qy), .out_tag(tag_y));

   // ------------------------------------------ stage 4: ndc sat, offset
   logic               v4_ff, f4_ff;
   logic signed [31:0] w4_ff;
   logic signed [33:0] ax_ff, ay_ff;
   logic signed [31:0] nx, ny;
   assign nx = sat64(64'(qx));
   assign ny = sat64(64'(qy));
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= dv_x;
      f4_ff <= tag_x[TagW-1];
      w4_ff <= tag_x[31:0];
      ax_ff <= (34'sd1 <<< FRAC_BITS) + 34'(nx);
      ay_ff <= (34'sd1 <<< FRAC_BITS) - 34'(ny);
   end

   // ---------------------------------------- stage 5: scale, output reg
   logic signed [48:0] mx, my;
   assign mx = $signed({1'b0, width_ff})  * ax_ff;
   assign my = $signed({1'b0, height_ff}) * ay_ff;

   logic               rv_ff, rf_ff;
   logic signed [31:0] rx_ff, ry_ff, rw_ff;
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else rv_ff <= v4_ff;
      rf_ff <= f4_ff;
      rx_ff <= f4_ff ? sat64(64'(mx >>> 1)) : '0;
      ry_ff <= f4_ff ? sat64(64'(my >>> 1)) : '0;
      rw_ff <= f4_ff ? w4_ff : '0;
   end

   assign rsp_valid    = rv_ff;
   assign rsp_in_front = rf_ff;
   assign rsp_screen_x = rx_ff;
   assign rsp_screen_y = ry_ff;
   assign rsp_clip_w   = rw_ff;

   logic unused_ok;
   assign unused_ok = dv_y ^ (|tag_y) ^ (|csr_paddr);
endmodule
`default_nettype wire

// ===== hdl/wts_checker.sv =====
// ----------------------------------------------------------------------------
// wts_checker
// port-level checks for the projection core
// ----------------------------------------------------------------------------
`default_nettype none
module wts_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire logic               rsp_in_front,
   input wire logic signed [31:0] rsp_screen_x,
   input wire logic signed [31:0] rsp_screen_y,
   input wire logic signed [31:0] rsp_clip_w,
   input wire logic               csr_pready
);
   a_busy: assert property (@(posedge clock) !busy) else $error("busy high");
   a_ready: assert property (@(posedge clock) csr_pready) else $error("pready low");
   a_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_front |-> rsp_screen_x == 0 && rsp_screen_y == 0
      && rsp_clip_w == 0) else $error("behind point not zeroed");
   a_w: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_front |-> rsp_clip_w > 0) else $error("w not positive");
endmodule

bind world_to_screen_projection_core wts_checker u_wts_checker (.*);
`default_nettype wire
